// ===== sv/lsra_pkg.sv =====
package lsra_pkg;

  localparam int MaxRegs = 16;
  localparam int IdxW = $clog2(MaxRegs);
  localparam int CntW = $clog2(MaxRegs + 1);
  localparam int PosW = 16;
  localparam int IdW = 16;
  localparam int PoolW = 5;
  localparam int OutcomeW = 2;
  localparam int RegOutW = 4;

  localparam logic [OutcomeW-1:0] OC_FREE = 2'd0;
  localparam logic [OutcomeW-1:0] OC_EVICT = 2'd1;
  localparam logic [OutcomeW-1:0] OC_SPILL = 2'd2;

  typedef struct packed {
    logic [PosW-1:0] end_pos;
    logic [IdW-1:0] value;
    logic [IdxW-1:0] reg_idx;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

// ===== sv/lsra_cell.sv =====
module lsra_cell (
  input  logic               clk,
  input  lsra_pkg::cell_ctl_t ctl,
  input  lsra_pkg::entry_t   nbr_i,
  input  lsra_pkg::entry_t   load_i,
  output lsra_pkg::entry_t   q_o
);

  lsra_pkg::entry_t q_r;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      q_r <= nbr_i;
    end else if (ctl.load) begin
      q_r <= load_i;
    end
  end

  assign q_o = q_r;

endmodule

// ===== sv/linear_scan_register_allocator_core.sv =====
// A new item is taken only when idle; in_stall is high until the result is handed on.
// The expiry pass walks the n active entries, and when no register is free the
// worst-end pass walks them again to find the entry with the latest end.
// Each pass takes one active-list cell per cycle; an expired cell is shifted out.
// Reset (rst_n low, synchronous) sets pool size 16, empties the active list and
// fills the free stack with indices 0 upward.
module linear_scan_register_allocator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_first_of_group,
  input  logic [15:0] in_value_id,
  input  logic [15:0] in_start_pos,
  input  logic [15:0] in_end_pos,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_value_id_out,
  output logic [1:0]  out_outcome,
  output logic [3:0]  out_reg_index,
  output logic [15:0] out_evicted_id
);

  localparam int N = lsra_pkg::MaxRegs;
  localparam int IW = lsra_pkg::IdxW;
  localparam int CW = lsra_pkg::CntW;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EXPIRE = 4'b0010,
    ST_SEARCH = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [lsra_pkg::PoolW-1:0] pool_r;
  logic [CW-1:0] act_cnt_r, act_cnt_nxt;
  logic [CW-1:0] free_cnt_r, free_cnt_nxt;
  logic [IW-1:0] free_stack_r [N];
  logic [CW-1:0] p_r, p_nxt;
  logic [IW-1:0] worst_r, worst_nxt;
  logic [lsra_pkg::PosW-1:0] worst_end_r, worst_end_nxt;
  logic [15:0] vid_r, start_r, end_r;
  logic [1:0] res_oc_r, res_oc_nxt;
  logic [IW-1:0] res_reg_r, res_reg_nxt;
  logic [15:0] res_ev_r, res_ev_nxt;
  logic out_valid_r;
  logic [15:0] out_vid_r, out_ev_r;
  logic [1:0] out_oc_r;
  logic [3:0] out_reg_r;

  lsra_pkg::entry_t cell_q [N];
  lsra_pkg::cell_ctl_t cell_ctl [N];
  lsra_pkg::entry_t ld_data;
  logic [IW-1:0] ld_idx;
  logic ld_en, rm_en, push_en, pop_en, refill;
  lsra_pkg::entry_t cur;
  logic [CW-1:0] pool_sat;
  logic out_free;

  assign cur = cell_q[p_r[IW-1:0]];
  assign pool_sat = (pool_r > CW'(N)) ? CW'(N) : CW'(pool_r);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    act_cnt_nxt = act_cnt_r;
    free_cnt_nxt = free_cnt_r;
    p_nxt = p_r;
    worst_nxt = worst_r;
    worst_end_nxt = worst_end_r;
    res_oc_nxt = res_oc_r;
    res_reg_nxt = res_reg_r;
    res_ev_nxt = res_ev_r;
    ld_en = 1'b0;
    ld_idx = '0;
    ld_data = cur;
    rm_en = 1'b0;
    push_en = 1'b0;
    pop_en = 1'b0;
    refill = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          p_nxt = '0;
          if (in_first_of_group) begin
            refill = 1'b1;
            act_cnt_nxt = '0;
            free_cnt_nxt = pool_sat;
          end
          state_nxt = ST_EXPIRE;
        end
      end
      ST_EXPIRE: begin
        if (p_r < act_cnt_r) begin
          if (cur.end_pos < start_r) begin
            rm_en = 1'b1;
            act_cnt_nxt = act_cnt_r - 1'b1;
            if (free_cnt_r < CW'(N)) begin
              push_en = 1'b1;
              free_cnt_nxt = free_cnt_r + 1'b1;
            end
          end else begin
            p_nxt = p_r + 1'b1;
          end
        end else if (free_cnt_r != '0 && act_cnt_r < CW'(N)) begin
          pop_en = 1'b1;
          free_cnt_nxt = free_cnt_r - 1'b1;
          ld_en = 1'b1;
          ld_idx = act_cnt_r[IW-1:0];
          ld_data.end_pos = end_r;
          ld_data.value = vid_r;
          ld_data.reg_idx = free_stack_r[free_cnt_nxt[IW-1:0]];
          act_cnt_nxt = act_cnt_r + 1'b1;
          res_oc_nxt = lsra_pkg::OC_FREE;
          res_reg_nxt = ld_data.reg_idx;
          res_ev_nxt = '0;
          state_nxt = ST_FINISH;
        end else if (act_cnt_r != '0) begin
          p_nxt = CW'(1);
          worst_nxt = '0;
          worst_end_nxt = cell_q[0].end_pos;
          state_nxt = ST_SEARCH;
        end else begin
          res_oc_nxt = lsra_pkg::OC_SPILL;
          res_reg_nxt = '0;
          res_ev_nxt = '0;
          state_nxt = ST_FINISH;
        end
      end
      ST_SEARCH: begin
        if (p_r < act_cnt_r) begin
          if (cur.end_pos > worst_end_r) begin
            worst_nxt = p_r[IW-1:0];
            worst_end_nxt = cur.end_pos;
          end
          p_nxt = p_r + 1'b1;
        end else if (worst_end_r > end_r) begin
          ld_en = 1'b1;
          ld_idx = worst_r;
          ld_data = cell_q[worst_r];
          ld_data.end_pos = end_r;
          ld_data.value = vid_r;
          res_oc_nxt = lsra_pkg::OC_EVICT;
          res_reg_nxt = cell_q[worst_r].reg_idx;
          res_ev_nxt = cell_q[worst_r].value;
          state_nxt = ST_FINISH;
        end else begin
          res_oc_nxt = lsra_pkg::OC_SPILL;
          res_reg_nxt = '0;
          res_ev_nxt = '0;
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    assign cell_ctl[i] = '{shift: rm_en && (CW'(i) >= p_r),
                           load: ld_en && (ld_idx == IW'(i))};
    lsra_cell u_cell (
      .clk    (clk),
      .ctl    (cell_ctl[i]),
      .nbr_i  (cell_q[(i + 1) % N]),
      .load_i (ld_data),
      .q_o    (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) begin
        free_stack_r[i] <= IW'(i);
      end
    end else if (refill) begin
      for (int i = 0; i < N; i++) begin
        free_stack_r[i] <= IW'(i);
      end
    end else if (push_en) begin
      free_stack_r[free_cnt_r[IW-1:0]] <= cur.reg_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pool_r <= lsra_pkg::PoolW'(N);
      act_cnt_r <= '0;
      free_cnt_r <= CW'(N);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      act_cnt_r <= act_cnt_nxt;
      free_cnt_r <= free_cnt_nxt;
      if (cfg_we) begin
        pool_r <= cfg_wdata;
      end
      if (state_r == ST_FINISH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
    worst_r <= worst_nxt;
    worst_end_r <= worst_end_nxt;
    res_oc_r <= res_oc_nxt;
    res_reg_r <= res_reg_nxt;
    res_ev_r <= res_ev_nxt;
    if (state_r == ST_IDLE && in_valid) begin
      vid_r <= in_value_id;
      start_r <= in_start_pos;
      end_r <= in_end_pos;
    end
    if (state_r == ST_FINISH && out_free) begin
      out_vid_r <= vid_r;
      out_oc_r <= res_oc_r;
      out_reg_r <= 4'(res_reg_r);
      out_ev_r <= res_ev_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value_id_out = out_vid_r;
  assign out_outcome = out_oc_r;
  assign out_reg_index = out_reg_r;
  assign out_evicted_id = out_ev_r;

  a_act_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    act_cnt_r <= CW'(N)) else $error("active count overflow");
  a_free_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    free_cnt_r <= CW'(N)) else $error("free count overflow");
  a_spill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_oc_r == lsra_pkg::OC_SPILL) |-> (out_reg_r == '0 && out_ev_r == '0))
    else $error("spill result carries a register");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_valid) |=> state_r == ST_EXPIRE)
    else $error("accepted item not started");

endmodule
